// ===== design/fmtg_pkg.sv =====
// Shared constants, widths and the gamma threshold table for the filmic tone mapper.
`timescale 1ns / 1ps
package fmtg_pkg;

  localparam int CH            = 3;
  localparam int IN_W          = 20;
  localparam int OUT_W         = 8;
  localparam int TONE_W        = 17;
  localparam int Q_W           = 16;
  localparam int FRAC_BITS_DEF = 16;

  // Width of the curve coefficients 251r+3s and 243r+59s.
  function automatic int coef_w(input int fb);
    int hi;
    hi = (IN_W + 8 > fb + 6) ? IN_W + 8 : fb + 6;
    return hi + 1;
  endfunction

  // Width of numerator and denominator of the curve.
  function automatic int frac_w(input int fb);
    int hi;
    hi = (IN_W + coef_w(fb) > 2 * fb + 4) ? IN_W + coef_w(fb) : 2 * fb + 4;
    return hi + 1;
  endfunction

  typedef logic [TONE_W-1:0] thr_tab_t [256];

  // Smallest tone value (65536 = 1.0) that reaches each display code.
  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    real      v;
    for (int c = 0; c < 256; c++) begin
      v = 65536.0 * ((real'(c) / 255.0) ** 2.2);
      tab[c] = TONE_W'($rtoi($ceil(v)));
    end
    return tab;
  endfunction

  localparam thr_tab_t GAMMA_THR = build_thr();

endpackage

// ===== design/fmtg_curve.sv =====
// Two-stage front end: filmic curve numerator and denominator per channel.
`timescale 1ns / 1ps
module fmtg_curve #(
  parameter int FRAC_BITS = fmtg_pkg::FRAC_BITS_DEF,
  localparam int AW = fmtg_pkg::coef_w(FRAC_BITS),
  localparam int DW = fmtg_pkg::frac_w(FRAC_BITS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_v,
  output logic                      up_rdy,
  input  logic [fmtg_pkg::IN_W-1:0] raw [fmtg_pkg::CH],
  output logic                      out_v,
  input  logic                      dn_rdy,
  output logic [DW-1:0]             num [fmtg_pkg::CH],
  output logic [DW-1:0]             den [fmtg_pkg::CH]
);
  import fmtg_pkg::*;

  localparam logic [AW-1:0] S3  = AW'(3) << FRAC_BITS;
  localparam logic [AW-1:0] S59 = AW'(59) << FRAC_BITS;
  localparam logic [DW-1:0] C14 = DW'(14) << (2 * FRAC_BITS);

  logic            v0_r, v1_r, rdy0, rdy1;
  logic [IN_W-1:0] r_r   [CH];
  logic [AW-1:0]   a_r   [CH];
  logic [AW-1:0]   b_r   [CH];
  logic [AW-1:0]   a_nxt [CH];
  logic [AW-1:0]   b_nxt [CH];
  logic [DW-1:0]   num_r [CH];
  logic [DW-1:0]   den_r [CH];
  logic [DW-1:0]   num_nxt [CH];
  logic [DW-1:0]   den_nxt [CH];

  assign rdy1   = !v1_r || dn_rdy;
  assign rdy0   = !v0_r || rdy1;
  assign up_rdy = rdy0;
  assign out_v  = v1_r;

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      a_nxt[c]   = AW'(raw[c]) * AW'(251) + S3;
      b_nxt[c]   = AW'(raw[c]) * AW'(243) + S59;
      num_nxt[c] = DW'(r_r[c]) * DW'(a_r[c]);
      den_nxt[c] = DW'(r_r[c]) * DW'(b_r[c]) + C14;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_v;
      if (rdy1) v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_v) begin
      r_r <= raw;
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
    if (rdy1 && v0_r) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  assign num = num_r;
  assign den = den_r;

endmodule

// ===== design/fmtg_div.sv =====
// Restoring divider, one quotient bit per stage, giving the 17-bit tone value.
`timescale 1ns / 1ps
module fmtg_div #(
  parameter int FRAC_BITS = fmtg_pkg::FRAC_BITS_DEF,
  localparam int DW = fmtg_pkg::frac_w(FRAC_BITS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  output logic                        up_rdy,
  input  logic [DW-1:0]               num [fmtg_pkg::CH],
  input  logic [DW-1:0]               den [fmtg_pkg::CH],
  output logic                        out_v,
  input  logic                        dn_rdy,
  output logic [fmtg_pkg::TONE_W-1:0] tone [fmtg_pkg::CH]
);
  import fmtg_pkg::*;

  localparam int NS = Q_W;

  logic [NS:0]    v_w;
  logic [NS-1:0]  v_r, rdy;
  logic [DW-1:0]  rem_w [NS+1][CH];
  logic [DW-1:0]  den_w [NS+1][CH];
  logic [Q_W-1:0] q_w   [NS+1][CH];
  logic [CH-1:0]  sat_w [NS+1];
  logic [DW-1:0]  rem_r [NS][CH];
  logic [DW-1:0]  den_r [NS][CH];
  logic [Q_W-1:0] q_r   [NS][CH];
  logic [CH-1:0]  sat_r [NS];

  assign v_w[0]   = in_v;
  assign rem_w[0] = num;
  assign den_w[0] = den;
  assign q_w[0]   = '{default: '0};
  assign up_rdy   = rdy[0];

  always_comb begin
    for (int c = 0; c < CH; c++) sat_w[0][c] = (num[c] >= den[c]);
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW:0]    sh      [CH];
    logic [CH-1:0]  ge;
    logic [DW-1:0]  rem_nxt [CH];
    logic [Q_W-1:0] q_nxt   [CH];

    if (k == NS - 1) begin : g_last
      assign rdy[k] = !v_r[k] || dn_rdy;
    end else begin : g_mid
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end

    always_comb begin
      for (int c = 0; c < CH; c++) begin
        sh[c]      = {rem_w[k][c], 1'b0};
        ge[c]      = (sh[c] >= {1'b0, den_w[k][c]});
        rem_nxt[c] = ge[c] ? DW'(sh[c] - {1'b0, den_w[k][c]}) : DW'(sh[c]);
        q_nxt[c]   = {q_w[k][c][Q_W-2:0], ge[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_w[k]) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_w[k];
        q_r[k]   <= q_nxt;
        sat_r[k] <= sat_w[k];
      end
    end

    assign v_w[k+1]   = v_r[k];
    assign rem_w[k+1] = rem_r[k];
    assign den_w[k+1] = den_r[k];
    assign q_w[k+1]   = q_r[k];
    assign sat_w[k+1] = sat_r[k];
  end

  assign out_v = v_w[NS];

  // Curve at or above one saturates to full scale.
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      tone[c] = sat_w[NS][c] ? TONE_W'(1) << Q_W : {1'b0, q_w[NS][c]};
    end
  end

endmodule

// ===== design/fmtg_gamma.sv =====
// Gamma encode: binary search of the threshold table, one code bit per stage.
`timescale 1ns / 1ps
module fmtg_gamma (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  output logic                        up_rdy,
  input  logic [fmtg_pkg::TONE_W-1:0] tone [fmtg_pkg::CH],
  output logic                        out_v,
  input  logic                        dn_rdy,
  output logic [fmtg_pkg::OUT_W-1:0]  code [fmtg_pkg::CH]
);
  import fmtg_pkg::*;

  localparam int NS = OUT_W;

  logic [NS:0]       v_w;
  logic [NS-1:0]     v_r, rdy;
  logic [TONE_W-1:0] t_w    [NS+1][CH];
  logic [OUT_W-1:0]  code_w [NS+1][CH];
  logic [TONE_W-1:0] t_r    [NS][CH];
  logic [OUT_W-1:0]  code_r [NS][CH];

  assign v_w[0]    = in_v;
  assign t_w[0]    = tone;
  assign code_w[0] = '{default: '0};
  assign up_rdy    = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [OUT_W-1:0] trial    [CH];
    logic [OUT_W-1:0] code_nxt [CH];

    if (k == NS - 1) begin : g_last
      assign rdy[k] = !v_r[k] || dn_rdy;
    end else begin : g_mid
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end

    // Keep the trial bit when its threshold is reached.
    always_comb begin
      for (int c = 0; c < CH; c++) begin
        trial[c]             = code_w[k][c];
        trial[c][NS-1-k]     = 1'b1;
        code_nxt[c] = (GAMMA_THR[trial[c]] <= t_w[k][c]) ? trial[c] : code_w[k][c];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_w[k]) begin
        t_r[k]    <= t_w[k];
        code_r[k] <= code_nxt;
      end
    end

    assign v_w[k+1]    = v_r[k];
    assign t_w[k+1]    = t_r[k];
    assign code_w[k+1] = code_r[k];
  end

  assign out_v = v_w[NS];
  assign code  = code_w[NS];

endmodule

// ===== design/filmic_tone_map_gamma_core.sv =====
// Top level of the filmic tone mapper with gamma 2.2 encode.
//
//  channel  ports                               transfer when
//  input    in_valid, in_stall, in_*_in (20b)   in_valid && !in_stall
//  output   out_valid, out_stall, out_*_out (8b) out_valid && !out_stall
//
// One pixel per cycle sustained while out_stall stays low; 2 curve stages,
// 16 divider stages (one quotient bit each), 8 gamma search stages.
// Synchronous active-low reset clears all stage valid bits.
// Each stage advances when it is empty or the next stage advances, so
// bubbles close up under output stall; in_stall rises only when every
// stage holds a pixel.
`timescale 1ns / 1ps
module filmic_tone_map_gamma_core #(
  parameter int FRAC_BITS = fmtg_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fmtg_pkg::IN_W-1:0]  in_red_in,
  input  logic [fmtg_pkg::IN_W-1:0]  in_green_in,
  input  logic [fmtg_pkg::IN_W-1:0]  in_blue_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fmtg_pkg::OUT_W-1:0] out_red_out,
  output logic [fmtg_pkg::OUT_W-1:0] out_green_out,
  output logic [fmtg_pkg::OUT_W-1:0] out_blue_out
);
  import fmtg_pkg::*;

  localparam int DW = frac_w(FRAC_BITS);

  logic              crv_rdy, crv_v, div_rdy, div_v, gam_rdy;
  logic [IN_W-1:0]   raw  [CH];
  logic [DW-1:0]     num  [CH];
  logic [DW-1:0]     den  [CH];
  logic [TONE_W-1:0] tone [CH];
  logic [OUT_W-1:0]  code [CH];

  assign raw[0] = in_red_in;
  assign raw[1] = in_green_in;
  assign raw[2] = in_blue_in;

  fmtg_curve #(.FRAC_BITS(FRAC_BITS)) u_curve (
    .clk(clk), .rst_n(rst_n),
    .in_v(in_valid), .up_rdy(crv_rdy), .raw(raw),
    .out_v(crv_v), .dn_rdy(div_rdy), .num(num), .den(den)
  );

  fmtg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n),
    .in_v(crv_v), .up_rdy(div_rdy), .num(num), .den(den),
    .out_v(div_v), .dn_rdy(gam_rdy), .tone(tone)
  );

  fmtg_gamma u_gamma (
    .clk(clk), .rst_n(rst_n),
    .in_v(div_v), .up_rdy(gam_rdy), .tone(tone),
    .out_v(out_valid), .dn_rdy(!out_stall), .code(code)
  );

  assign in_stall      = !crv_rdy;
  assign out_red_out   = code[0];
  assign out_green_out = code[1];
  assign out_blue_out  = code[2];

  // A full pipe is the only reason to hold off the input.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side can advance");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  a_gamma_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid) |-> !in_stall)
    else $error("input stalled with empty output stage");

endmodule

// ===== test/tb_top.sv =====
// Self-checking regression for the filmic tone mapper with gamma encode.
`timescale 1ns / 1ps
module tb_top;
  import fmtg_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } pixel_code_t;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int TONE_ONE  = 65536;
  localparam int MAX_GAP   = 19;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [IN_W-1:0]  in_red_in = '0;
  logic [IN_W-1:0]  in_green_in = '0;
  logic [IN_W-1:0]  in_blue_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] out_red_out;
  logic [OUT_W-1:0] out_green_out;
  logic [OUT_W-1:0] out_blue_out;

  pixel_code_t pending_codes[$];
  int          mismatches = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;

  filmic_tone_map_gamma_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out)
  );

  always #1 clk = ~clk;

  // Curve value quantized to 1/65536, saturated at 1.0.
  function automatic logic [TONE_W-1:0] tone_level(input logic [IN_W-1:0] raw);
    logic [63:0] r, s, num, den, rem;
    logic [15:0] q;
    r = 64'(raw);
    s = 64'd1 << FB;
    num = r * (64'd251 * r + 64'd3 * s);
    den = r * (64'd243 * r + 64'd59 * s) + 64'd14 * s * s;
    if (num >= den) return TONE_W'(TONE_ONE);
    rem = num;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return TONE_W'(q);
  endfunction

  function automatic logic [383:0] wide_pow(input logic [383:0] base, input int n);
    logic [383:0] acc;
    acc = 384'd1;
    for (int i = 0; i < n; i++) acc = acc * base;
    return acc;
  endfunction

  // Largest code c with (c/255)^2.2 <= t/65536, in exact integer form.
  function automatic logic [OUT_W-1:0] display_code(input logic [TONE_W-1:0] t);
    logic [383:0] rhs, lhs, scale;
    int lo, hi, mid;
    rhs = wide_pow(384'(t), 10) * wide_pow(384'd255, 22);
    scale = wide_pow(384'(TONE_ONE), 10);
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = wide_pow(384'(mid), 22) * scale;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return OUT_W'(lo);
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_pixel(input logic [IN_W-1:0] r, input logic [IN_W-1:0] g,
                            input logic [IN_W-1:0] b);
    int gap;
    pixel_code_t exp_code;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    exp_code.red = display_code(tone_level(r));
    exp_code.green = display_code(tone_level(g));
    exp_code.blue = display_code(tone_level(b));
    pending_codes = {pending_codes, exp_code};
  endtask

  function automatic logic [IN_W-1:0] rand_radiance();
    case ($urandom_range(0, 3))
      0: return IN_W'($urandom);
      1: return IN_W'($urandom_range(0, 4 * TONE_ONE));
      2: return IN_W'($urandom_range(0, 4096));
      default: return IN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_extremes();
    logic [IN_W-1:0] pts[8];
    pts = '{20'd0, 20'd1, 20'd2, 20'hFFFFF, 20'hFFFFE, 20'h10000, 20'h80000, 20'h7FFFF};
    foreach (pts[i]) send_pixel(pts[i], pts[(i + 3) % 8], pts[(i + 5) % 8]);
  endtask

  // Walk single bits and low-end points where the gamma curve is steep.
  task automatic test_curve_points();
    for (int i = 0; i < IN_W; i += 2)
      send_pixel(IN_W'(1) << i, IN_W'(1) << (i + 1), ~(IN_W'(1) << i));
    send_pixel(20'd16, 20'd64, 20'd200);
  endtask

  task automatic test_random_pixels();
    for (int i = 0; i < 1600; i++) begin
      if (i % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_pixel(rand_radiance(), rand_radiance(), rand_radiance());
    end
    no_idle = 1'b0;
  endtask

  // Result side: stall per transfer, compare against the oldest expectation.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pixel_code_t exp_code;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %0d %0d %0d",
                                       out_red_out, out_green_out, out_blue_out);
      end else begin
        exp_code = pending_codes.pop_front();
        if (out_red_out !== exp_code.red || out_green_out !== exp_code.green ||
            out_blue_out !== exp_code.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     exp_code.red, exp_code.green, exp_code.blue,
                     out_red_out, out_green_out, out_blue_out);
        end
      end
      stall_left <= draw_gap();
    end
  end

  initial begin
    #5_000_000;
    $display("filmic_tone_map_gamma_core regression: fail");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_curve_points();
    test_random_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_codes.size() == 0)
      $display("filmic_tone_map_gamma_core regression: pass");
    else
      $display("filmic_tone_map_gamma_core regression: fail");
    $finish;
  end
endmodule
